// File: design/rcfd_pkg.sv
// ----------------------------------------------------------------------------
// Remote command frame decoder package
// Shared widths, header bytes, result kind codes, register indexes and the
// direction code table.
// ----------------------------------------------------------------------------
package rcfd_pkg;

	localparam int GAIN_WIDTH_DEF = 32;
	localparam int POSITION_WIDTH_DEF = 16;

	localparam int BYTE_W = 8;
	localparam int GAIN_COUNT = 5;
	localparam int GI_W = $clog2(GAIN_COUNT + 1);
	localparam int LEFT_W = 8;
	localparam int DIGIT_W = 4;

	localparam logic [BYTE_W-1:0] HDR_CMD = 8'h79;
	localparam logic [BYTE_W-1:0] HDR_DIR = 8'h64;
	localparam logic [BYTE_W-1:0] HDR_KEY = 8'h62;
	localparam logic [BYTE_W-1:0] HDR_PARAM0 = 8'hAA;
	localparam logic [BYTE_W-1:0] HDR_PARAM1 = 8'hAF;
	localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
	localparam logic [BYTE_W-1:0] ASCII_NINE = 8'h39;

	localparam int KIND_W = 2;
	localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DIR = 2'd1;
	localparam logic [KIND_W-1:0] KIND_KEY = 2'd2;
	localparam logic [KIND_W-1:0] KIND_PARAM = 2'd3;

	localparam int CODE_W = 4;
	localparam logic [CODE_W-1:0] DIR_NONE = 4'd0;
	localparam logic [CODE_W-1:0] DIR_FRONT = 4'd1;
	localparam logic [CODE_W-1:0] DIR_REAR = 4'd2;
	localparam logic [CODE_W-1:0] DIR_LEFT = 4'd3;
	localparam logic [CODE_W-1:0] DIR_RIGHT = 4'd4;
	localparam logic [CODE_W-1:0] DIR_LFRONT = 4'd5;
	localparam logic [CODE_W-1:0] DIR_RFRONT = 4'd6;
	localparam logic [CODE_W-1:0] DIR_LREAR = 4'd7;
	localparam logic [CODE_W-1:0] DIR_RREAR = 4'd8;
	localparam logic [CODE_W-1:0] DIR_STOP = 4'd9;

	localparam logic [BYTE_W-1:0] KEY_FIRST = 8'd1;
	localparam logic [BYTE_W-1:0] KEY_LAST = 8'd9;
	localparam logic [BYTE_W-1:0] KEY_THREE = 8'd3;
	localparam logic [BYTE_W-1:0] KEY_FOUR = 8'd4;
	localparam logic [BYTE_W-1:0] KEY_FIVE = 8'd5;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_KEY3 = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_KEY4 = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_KEY5 = 2'd2;
	localparam logic [CFG_DATA_W-1:0] SPEED_KEY3_RST = 8'd40;
	localparam logic [CFG_DATA_W-1:0] SPEED_KEY4_RST = 8'd30;
	localparam logic [CFG_DATA_W-1:0] SPEED_KEY5_RST = 8'd20;

	function automatic logic [CODE_W-1:0] dir_of(input logic [BYTE_W-1:0] c0,
			input logic [BYTE_W-1:0] c1);
		logic [CODE_W-1:0] d;
		case ({c0, c1})
			16'hFF0F: d = DIR_FRONT;
			16'h5A00: d = DIR_REAR;
			16'hB400: d = DIR_LEFT;
			16'h0100: d = DIR_RIGHT;
			16'hDF00: d = DIR_LFRONT;
			16'hFF3B: d = DIR_RFRONT;
			16'h8600: d = DIR_LREAR;
			16'h2B00: d = DIR_RREAR;
			16'hFFFF: d = DIR_STOP;
			default: d = DIR_NONE;
		endcase
		return d;
	endfunction

endpackage

// File: design/rcfd_if.sv
// ----------------------------------------------------------------------------
// Remote command frame decoder channels
// Valid/ready channels for incoming frame bytes and for decoded results.
// ----------------------------------------------------------------------------
interface rcfd_frame_if import rcfd_pkg::*;;
	logic valid;
	logic ready;
	logic [BYTE_W-1:0] frame_byte;
	logic last_byte;

	modport source(output valid, output frame_byte, output last_byte, input ready);
	modport sink(input valid, input frame_byte, input last_byte, output ready);
endinterface

interface rcfd_result_if import rcfd_pkg::*; #(
	parameter int GAIN_WIDTH = GAIN_WIDTH_DEF
);
	logic valid;
	logic ready;
	logic [KIND_W-1:0] data_kind;
	logic [CODE_W-1:0] direction;
	logic [CODE_W-1:0] key_code;
	logic [BYTE_W-1:0] speed;
	logic [GAIN_WIDTH-1:0] balance_p_gain;
	logic [GAIN_WIDTH-1:0] balance_i_gain;
	logic [GAIN_WIDTH-1:0] balance_d_gain;
	logic [GAIN_WIDTH-1:0] velocity_p_gain;
	logic [GAIN_WIDTH-1:0] velocity_i_gain;
	logic gains_updated;
	logic frame_error;

	modport source(output valid, output data_kind, output direction, output key_code,
		output speed, output balance_p_gain, output balance_i_gain, output balance_d_gain,
		output velocity_p_gain, output velocity_i_gain, output gains_updated,
		output frame_error, input ready);
	modport sink(input valid, input data_kind, input direction, input key_code,
		input speed, input balance_p_gain, input balance_i_gain, input balance_d_gain,
		input velocity_p_gain, input velocity_i_gain, input gains_updated,
		input frame_error, output ready);
endinterface

// File: design/remote_command_frame_decoder.sv
// ----------------------------------------------------------------------------
// Remote command frame decoder
// Decodes direction, key and gain parameter frames one byte per beat.
// ----------------------------------------------------------------------------
// When not stalled, the decoder takes one frame byte per clock cycle; it gives
// one result beat in the cycle after the byte marked last. Every byte is fully
// handled in the cycle it is accepted: a header compare, a count capture or
// one multiply-by-ten-and-add step of the gain digits, including the closing
// of any following gains whose digit count is zero. The result is held in the
// decoder's own state registers, so the frame input stalls only while a
// result beat waits on the result channel; with the result side always ready,
// the sustained rate is one byte per cycle.
module remote_command_frame_decoder import rcfd_pkg::*; #(
	parameter int GAIN_WIDTH = GAIN_WIDTH_DEF,
	parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	rcfd_frame_if.sink frame,
	rcfd_result_if.source result,
	input logic wr_en,
	input logic [CFG_INDEX_W-1:0] wr_index,
	input logic [CFG_DATA_W-1:0] wr_data
);

	localparam int POS_W = POSITION_WIDTH;
	localparam int SUM_W = GAIN_WIDTH + 4;
	localparam logic [POS_W-1:0] POS_MAX = '1;
	localparam logic [GAIN_WIDTH-1:0] GAIN_MAX = '1;
	localparam logic [GI_W-1:0] GI_DONE = GI_W'(GAIN_COUNT);

	logic [CFG_DATA_W-1:0] speed_k3_q, speed_k4_q, speed_k5_q;

	logic [POS_W-1:0] pos_q;
	logic [BYTE_W-1:0] lead_q [4];
	logic [LEFT_W-1:0] cnt_q [GAIN_COUNT];
	logic [GI_W-1:0] gi_q;
	logic [LEFT_W-1:0] left_q;
	logic [GAIN_WIDTH-1:0] acc_q;
	logic [GAIN_WIDTH-1:0] pend_q [GAIN_COUNT];
	logic [GAIN_WIDTH-1:0] commit_q [GAIN_COUNT];
	logic [CODE_W-1:0] dir_q, key_q;
	logic [BYTE_W-1:0] speed_q;
	logic [KIND_W-1:0] kind_q;
	logic bad_q;
	logic out_valid_q, updated_q, error_q;

	logic accept, last;
	logic [BYTE_W-1:0] b;
	logic [BYTE_W-1:0] lead0, lead1, lead2, lead3, h1;
	logic [LEFT_W-1:0] cnt_eff [GAIN_COUNT];
	logic is_param, at6, take, closing, is_digit;
	logic [DIGIT_W-1:0] digit;
	logic [SUM_W-1:0] sum;
	logic [GAIN_WIDTH-1:0] acc_new, acc_after, acc_d;
	logic [GI_W-1:0] s, nxt, gi_d;
	logic [LEFT_W-1:0] left_after, left_d;
	logic [GAIN_COUNT-1:0] pend_we;
	logic [GAIN_WIDTH-1:0] pend_val [GAIN_COUNT];
	logic bad_d;
	logic [POS_W-1:0] pos_d;
	logic is_dir, is_key, commit;
	logic [CODE_W-1:0] dcode;

	assign b = frame.frame_byte;
	assign last = frame.last_byte;
	assign frame.ready = !out_valid_q || result.ready;
	assign accept = frame.valid && frame.ready;

	always_comb begin
		lead0 = (pos_q == '0) ? b : lead_q[0];
		lead1 = (pos_q == POS_W'(1)) ? b : lead_q[1];
		lead2 = (pos_q == POS_W'(2)) ? b : lead_q[2];
		lead3 = (pos_q == POS_W'(3)) ? b : lead_q[3];
		h1 = (pos_q != '0) ? lead1 : '0;
		for (int k = 0; k < GAIN_COUNT; k++) begin
			cnt_eff[k] = (pos_q == POS_W'(k + 2)) ? b : cnt_q[k];
		end
		is_param = (pos_q != '0) && lead0 == HDR_PARAM0 && lead1 == HDR_PARAM1;
		at6 = is_param && pos_q == POS_W'(6);
		take = is_param && pos_q >= POS_W'(7) && gi_q < GI_DONE;

		is_digit = b >= ASCII_ZERO && b <= ASCII_NINE;
		digit = is_digit ? b[DIGIT_W-1:0] : '0;
		sum = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + SUM_W'(digit);
		acc_new = (sum[SUM_W-1:GAIN_WIDTH] != '0) ? GAIN_MAX : sum[GAIN_WIDTH-1:0];

		s = at6 ? '0 : gi_q;
		left_after = at6 ? cnt_eff[0] : left_q - LEFT_W'(1);
		acc_after = at6 ? '0 : acc_new;
		closing = (at6 || take) && left_after == '0;

		nxt = GI_DONE;
		for (int k = GAIN_COUNT - 1; k >= 0; k--) begin
			if (GI_W'(k) > s && cnt_eff[k] != '0) begin
				nxt = GI_W'(k);
			end
		end
		for (int k = 0; k < GAIN_COUNT; k++) begin
			pend_we[k] = closing && GI_W'(k) >= s && GI_W'(k) < nxt;
			pend_val[k] = (GI_W'(k) == s) ? acc_after : '0;
		end

		if (pos_q == '0) begin
			gi_d = '0;
			left_d = '0;
			acc_d = '0;
		end else if (closing) begin
			gi_d = nxt;
			left_d = (nxt < GI_DONE) ? cnt_eff[nxt] : '0;
			acc_d = '0;
		end else if (at6 || take) begin
			gi_d = s;
			left_d = left_after;
			acc_d = acc_after;
		end else begin
			gi_d = gi_q;
			left_d = left_q;
			acc_d = acc_q;
		end
		bad_d = (pos_q == '0) ? 1'b0 : (bad_q || (take && !is_digit));

		if (last) begin
			pos_d = '0;
		end else if (pos_q != POS_MAX) begin
			pos_d = pos_q + POS_W'(1);
		end else begin
			pos_d = pos_q;
		end

		is_dir = lead0 == HDR_CMD && h1 == HDR_DIR && pos_q >= POS_W'(3);
		is_key = lead0 == HDR_CMD && h1 == HDR_KEY && pos_q >= POS_W'(2);
		dcode = dir_of(lead2, lead3);
		commit = is_param && pos_q >= POS_W'(6) && gi_d >= GI_DONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_k3_q <= SPEED_KEY3_RST;
			speed_k4_q <= SPEED_KEY4_RST;
			speed_k5_q <= SPEED_KEY5_RST;
		end else if (wr_en) begin
			case (wr_index)
				CFG_SPEED_KEY3: speed_k3_q <= wr_data;
				CFG_SPEED_KEY4: speed_k4_q <= wr_data;
				CFG_SPEED_KEY5: speed_k5_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < 4; k++) begin
				if (pos_q == POS_W'(k)) begin
					lead_q[k] <= b;
				end
			end
			for (int k = 0; k < GAIN_COUNT; k++) begin
				if (is_param && pos_q == POS_W'(k + 2)) begin
					cnt_q[k] <= b;
				end
				if (pend_we[k]) begin
					pend_q[k] <= pend_val[k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			gi_q <= '0;
			left_q <= '0;
			acc_q <= '0;
			bad_q <= 1'b0;
			dir_q <= DIR_NONE;
			key_q <= '0;
			speed_q <= '0;
			kind_q <= KIND_NONE;
			out_valid_q <= 1'b0;
			updated_q <= 1'b0;
			error_q <= 1'b0;
			for (int k = 0; k < GAIN_COUNT; k++) begin
				commit_q[k] <= '0;
			end
		end else begin
			if (accept && last) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				pos_q <= pos_d;
				gi_q <= gi_d;
				left_q <= left_d;
				acc_q <= acc_d;
				bad_q <= bad_d;
				if (last) begin
					updated_q <= commit;
					error_q <= is_param && !is_dir && !is_key && (commit ? bad_d : 1'b1);
					if (is_dir) begin
						kind_q <= KIND_DIR;
						if (dcode != DIR_NONE) begin
							dir_q <= dcode;
						end
					end else if (is_key) begin
						kind_q <= KIND_KEY;
						if (lead2 >= KEY_FIRST && lead2 <= KEY_LAST) begin
							key_q <= lead2[CODE_W-1:0];
							if (lead2 == KEY_THREE) begin
								speed_q <= speed_k3_q;
							end else if (lead2 == KEY_FOUR) begin
								speed_q <= speed_k4_q;
							end else if (lead2 == KEY_FIVE) begin
								speed_q <= speed_k5_q;
							end
						end
					end else if (is_param) begin
						kind_q <= KIND_PARAM;
						if (commit) begin
							for (int k = 0; k < GAIN_COUNT; k++) begin
								commit_q[k] <= pend_we[k] ? pend_val[k] : pend_q[k];
							end
						end
					end
				end
			end
		end
	end

	assign result.valid = out_valid_q;
	assign result.data_kind = kind_q;
	assign result.direction = dir_q;
	assign result.key_code = key_q;
	assign result.speed = speed_q;
	assign result.balance_p_gain = commit_q[0];
	assign result.balance_i_gain = commit_q[1];
	assign result.balance_d_gain = commit_q[2];
	assign result.velocity_p_gain = commit_q[3];
	assign result.velocity_i_gain = commit_q[4];
	assign result.gains_updated = updated_q;
	assign result.frame_error = error_q;

`ifndef NO_ASSERTIONS
	a_updated_is_param: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && updated_q |-> kind_q == KIND_PARAM && gi_q == GI_DONE)
		else $error("Gains committed without a complete parameter frame.");
	a_gain_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		gi_q <= GI_DONE)
		else $error("Gain index past the last gain.");
	a_no_result_mid_frame: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !last |=> !out_valid_q)
		else $error("Result beat raised by a byte that is not last.");
	a_pos_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last |=> pos_q == '0 && out_valid_q)
		else $error("Frame end did not restart the byte position.");
`endif

endmodule
